[rtl/wprm_pkg.sv]
// Package for the waveform peak/RMS mipmap block: constants, command and status types.
// Used by wprm_ctrl, wprm_dp and waveform_peak_rms_mipmap.
`default_nettype none
package wprm_pkg;
	localparam int NUM_LEVELS       = 11;
	localparam int MAX_CHANNELS     = 8;
	localparam int SAMPLE_BITS      = 16;
	localparam int FRAME_COUNT_BITS = 24;
	localparam int LEVEL_BITS       = 4;
	localparam int CHAN_BITS        = 4;

	localparam logic [0:0] REG_CHANNEL_COUNT = 1'd0;
	localparam logic [0:0] REG_TOTAL_FRAMES  = 1'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEVEL,
		ST_DIV,
		ST_SQRT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic take;     // accept input sample
		logic lv_start; // start processing current level
		logic div_step;
		logic sqrt_step;
		logic emit;     // load output register
		logic skip;     // level has no result, move on
	} cmd_t;

	typedef struct packed {
		logic frame_ok; // accepted sample completed a frame within total_frames
		logic lv_active;
		logic lv_emits;
		logic div_done;
		logic sqrt_done;
		logic out_free;
	} sts_t;
endpackage
`default_nettype wire

[rtl/wprm_ctrl.sv]
// Controller state machine for the waveform mipmap block.
// Depends on wprm_pkg.
`default_nettype none
module wprm_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire wprm_pkg::sts_t sts,
	output wprm_pkg::cmd_t      cmd
);
	wprm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= wprm_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wprm_pkg::ST_IDLE: begin
				if (in_valid) state_d = wprm_pkg::ST_LEVEL;
			end
			wprm_pkg::ST_LEVEL: begin
				if (!sts.frame_ok || !sts.lv_active) state_d = wprm_pkg::ST_IDLE;
				else if (sts.lv_emits) state_d = wprm_pkg::ST_DIV;
			end
			wprm_pkg::ST_DIV: begin
				if (sts.div_done) state_d = wprm_pkg::ST_SQRT;
			end
			wprm_pkg::ST_SQRT: begin
				if (sts.sqrt_done) state_d = wprm_pkg::ST_EMIT;
			end
			wprm_pkg::ST_EMIT: begin
				// higher levels still accumulate even when none of them emits
				if (sts.out_free) state_d = wprm_pkg::ST_LEVEL;
			end
			default: state_d = wprm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			wprm_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
			end
			wprm_pkg::ST_LEVEL: begin
				if (sts.frame_ok && sts.lv_active) begin
					cmd.lv_start = sts.lv_emits;
					cmd.skip = !sts.lv_emits;
				end
			end
			wprm_pkg::ST_DIV: cmd.div_step = 1'b1;
			wprm_pkg::ST_SQRT: cmd.sqrt_step = 1'b1;
			wprm_pkg::ST_EMIT: cmd.emit = sts.out_free;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

[rtl/wprm_dp.sv]
// Datapath: frame mixing, per-level accumulators, serial divider and root, output register.
// Depends on wprm_pkg.
`default_nettype none
module wprm_dp #(
	parameter int NUM_LEVELS       = wprm_pkg::NUM_LEVELS,
	parameter int MAX_CHANNELS     = wprm_pkg::MAX_CHANNELS,
	parameter int SAMPLE_BITS      = wprm_pkg::SAMPLE_BITS,
	parameter int FRAME_COUNT_BITS = wprm_pkg::FRAME_COUNT_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire wprm_pkg::cmd_t                     cmd,
	output wprm_pkg::sts_t                          sts,
	input  wire logic [wprm_pkg::CHAN_BITS-1:0]     channel_count,
	input  wire logic [FRAME_COUNT_BITS-1:0]        total_frames,
	input  wire logic signed [SAMPLE_BITS-1:0]      sample,
	input  wire logic                               first,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [wprm_pkg::LEVEL_BITS-1:0]         level,
	output logic [FRAME_COUNT_BITS-1:0]             block_index,
	output logic signed [SAMPLE_BITS-1:0]           min_peak,
	output logic signed [SAMPLE_BITS-1:0]           max_peak,
	output logic [SAMPLE_BITS-1:0]                  rms_level,
	output logic                                    clipped,
	output logic                                    level_done,
	output logic                                    last
);
	localparam int LB   = wprm_pkg::LEVEL_BITS;
	localparam int CB   = wprm_pkg::CHAN_BITS;
	localparam int CPB  = $clog2(MAX_CHANNELS + 1);
	localparam int MSB  = SAMPLE_BITS + CPB;             // mix sum width
	localparam int RK   = MSB + CPB;                     // reciprocal scale bits
	localparam int CNTB = NUM_LEVELS;                    // count up to 2^(L-1)
	localparam int SQB  = 2 * SAMPLE_BITS + CNTB;        // square sum width
	localparam int DCB  = $clog2(SQB + 1);
	localparam int RTB  = SAMPLE_BITS + 1;               // root bits
	localparam int RCB  = $clog2(RTB + 1);
	localparam int LVB  = $clog2(NUM_LEVELS + 1);
	localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS:0] CLIP =
		(SAMPLE_BITS+1)'((64'd99 << (SAMPLE_BITS - 1)) / 64'd100);

	// effective channel count
	logic [CB-1:0] ch;
	always_comb begin
		ch = channel_count;
		if (ch == '0) ch = CB'(1);
		if ((CB+1)'(ch) > (CB+1)'(MAX_CHANNELS)) ch = CB'(MAX_CHANNELS);
	end

	logic [CB-1:0] chpos_q;
	logic signed [MSB-1:0] msum_q;
	logic [FRAME_COUNT_BITS-1:0] fcnt_q;
	logic clip_q, frame_ok_q, final_q;
	logic signed [SAMPLE_BITS-1:0] mix_q;
	logic [LVB-1:0] lv_q;
	logic signed [SAMPLE_BITS-1:0] lmin_q [NUM_LEVELS];
	logic signed [SAMPLE_BITS-1:0] lmax_q [NUM_LEVELS];
	logic [SQB-1:0] lsq_q [NUM_LEVELS];
	logic [CNTB:0] lcnt_q [NUM_LEVELS];
	logic [FRAME_COUNT_BITS-1:0] lbi_q [NUM_LEVELS];

	// sample intake; the mix is |sum| times ceil(2^RK / ch), shifted down, sign restored
	logic signed [MSB-1:0] sum_new;
	logic frame_end;
	logic signed [MSB-1:0] mix_full;
	logic [CB-1:0] cpos_base;
	logic signed [MSB-1:0] sum_base;
	logic [FRAME_COUNT_BITS-1:0] f_base;
	logic [RK:0] recip;
	logic [MSB-1:0] mag, quo;
	logic [MSB+RK:0] prod;
	always_comb begin
		cpos_base = first ? '0 : chpos_q;
		sum_base  = first ? '0 : msum_q;
		f_base    = first ? '0 : fcnt_q;
		sum_new   = sum_base + MSB'(sample);
		frame_end = !((cpos_base + CB'(1)) < ch);
		recip     = '0;
		for (int c = 1; c <= MAX_CHANNELS; c++) begin
			if (ch == CB'(c)) recip = (RK+1)'(((64'd1 << RK) + 64'(c) - 64'd1) / 64'(c));
		end
		mag      = sum_new[MSB-1] ? MSB'(-sum_new) : MSB'(sum_new);
		prod     = (MSB+RK+1)'(mag) * (MSB+RK+1)'(recip);
		quo      = prod[MSB+RK-1:RK];
		mix_full = sum_new[MSB-1] ? -$signed(quo) : $signed(quo);
	end

	logic [LB-1:0] lvn;
	logic [CNTB:0] cnt_next;
	logic signed [SAMPLE_BITS-1:0] nmin, nmax;
	logic [2*SAMPLE_BITS-1:0] sq;
	logic [SQB-1:0] nsq;
	logic [FRAME_COUNT_BITS:0] lv_size;
	logic [LVB-1:0] lv_idx;
	assign lv_idx = lv_q;
	always_comb begin
		lv_size  = (FRAME_COUNT_BITS+1)'(1) << lv_q;
		nmin     = (mix_q < lmin_q[lv_idx]) ? mix_q : lmin_q[lv_idx];
		nmax     = (mix_q > lmax_q[lv_idx]) ? mix_q : lmax_q[lv_idx];
		sq       = (2*SAMPLE_BITS)'(mix_q * mix_q);
		nsq      = lsq_q[lv_idx] + SQB'(sq);
		cnt_next = lcnt_q[lv_idx] + (CNTB+1)'(1);
		lvn      = LB'(lv_q);
	end
	assign sts.frame_ok  = frame_ok_q;
	assign sts.lv_active = (lv_q < LVB'(NUM_LEVELS)) &&
		((FRAME_COUNT_BITS+1)'(total_frames) > lv_size);
	assign sts.lv_emits  = ((FRAME_COUNT_BITS+1)'(cnt_next) >= lv_size) || final_q;

	// serial restoring divider: sumsq / count
	logic [SQB-1:0] dq_q;
	logic [SQB-1:0] drem_q;
	logic [CNTB:0] dden_q;
	logic [DCB-1:0] dcnt_q;
	logic [SQB:0] dtrial;
	assign dtrial = {drem_q, dq_q[SQB-1]} - (SQB+1)'(dden_q);
	assign sts.div_done = (dcnt_q == '0);

	// serial integer root, two bits per step
	logic [2*RTB-1:0] rv_q;
	logic [RTB+1:0] rrem_q;
	logic [RTB-1:0] rres_q;
	logic [RCB-1:0] rcnt_q;
	logic [RTB+1:0] rcur, rtr;
	assign rcur = {rrem_q[RTB-1:0], rv_q[2*RTB-1 -: 2]};
	assign rtr  = rcur - (RTB+2)'({rres_q, 2'b01});
	assign sts.sqrt_done = (rcnt_q == '0);
	assign sts.out_free  = !out_valid || !out_stall;

	// later emitting level exists? next active levels emit only if block full or final
	logic more;
	always_comb begin
		more = 1'b0;
		for (int l = 0; l < NUM_LEVELS; l++) begin
			if (LVB'(l) > lv_q && (FRAME_COUNT_BITS+1)'(total_frames) >
				((FRAME_COUNT_BITS+1)'(1) << l) &&
				(final_q || (FRAME_COUNT_BITS+1)'(lcnt_q[l] + (CNTB+1)'(1)) >=
				((FRAME_COUNT_BITS+1)'(1) << l)))
				more = 1'b1;
		end
	end

	logic signed [SAMPLE_BITS-1:0] omin_q, omax_q;
	logic [FRAME_COUNT_BITS-1:0] obi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chpos_q <= '0; msum_q <= '0; fcnt_q <= '0; clip_q <= 1'b0;
			frame_ok_q <= 1'b0; final_q <= 1'b0; lv_q <= '0; out_valid <= 1'b0;
			dcnt_q <= '0; rcnt_q <= '0;
			for (int l = 0; l < NUM_LEVELS; l++) begin
				lmin_q[l] <= SMAX; lmax_q[l] <= SMIN; lsq_q[l] <= '0;
				lcnt_q[l] <= '0; lbi_q[l] <= '0;
			end
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cmd.take) begin
				lv_q <= '0;
				frame_ok_q <= 1'b0;
				if (first) begin
					clip_q <= 1'b0;
					for (int l = 0; l < NUM_LEVELS; l++) begin
						lmin_q[l] <= SMAX; lmax_q[l] <= SMIN; lsq_q[l] <= '0;
						lcnt_q[l] <= '0; lbi_q[l] <= '0;
					end
				end
				if (!frame_end) begin
					chpos_q <= cpos_base + CB'(1);
					msum_q  <= sum_new;
					fcnt_q  <= f_base;
				end else begin
					chpos_q <= '0;
					msum_q  <= '0;
					mix_q   <= SAMPLE_BITS'(mix_full);
					fcnt_q  <= f_base;
					if (f_base < total_frames) begin
						fcnt_q <= f_base + FRAME_COUNT_BITS'(1);
						frame_ok_q <= 1'b1;
						final_q <= (f_base + FRAME_COUNT_BITS'(1)) == total_frames;
						if (mix_full > MSB'(CLIP) || mix_full < -MSB'(CLIP))
							clip_q <= 1'b1;
					end
				end
			end
			if (cmd.skip) begin
				lmin_q[lv_idx] <= nmin; lmax_q[lv_idx] <= nmax;
				lsq_q[lv_idx] <= nsq; lcnt_q[lv_idx] <= cnt_next;
				lv_q <= lv_q + LVB'(1);
			end
			if (cmd.lv_start) begin
				omin_q <= nmin; omax_q <= nmax; obi_q <= lbi_q[lv_idx];
				dq_q <= nsq; drem_q <= '0; dden_q <= cnt_next;
				dcnt_q <= DCB'(SQB);
				lmin_q[lv_idx] <= SMAX; lmax_q[lv_idx] <= SMIN;
				lsq_q[lv_idx] <= '0; lcnt_q[lv_idx] <= '0;
				lbi_q[lv_idx] <= lbi_q[lv_idx] + FRAME_COUNT_BITS'(1);
			end
			if (cmd.div_step && dcnt_q != '0) begin
				dcnt_q <= dcnt_q - DCB'(1);
				if (!dtrial[SQB]) begin
					drem_q <= dtrial[SQB-1:0];
					dq_q <= {dq_q[SQB-2:0], 1'b1};
				end else begin
					drem_q <= {drem_q[SQB-2:0], dq_q[SQB-1]};
					dq_q <= {dq_q[SQB-2:0], 1'b0};
				end
				if (dcnt_q == DCB'(1)) begin
					rcnt_q <= RCB'(RTB);
					rrem_q <= '0; rres_q <= '0;
				end
			end
			if (cmd.div_step && dcnt_q == DCB'(1)) begin
				rv_q <= (2*RTB)'(!dtrial[SQB] ? {dq_q[SQB-2:0], 1'b1} : {dq_q[SQB-2:0], 1'b0});
			end
			if (cmd.sqrt_step && rcnt_q != '0) begin
				rcnt_q <= rcnt_q - RCB'(1);
				rv_q <= {rv_q[2*RTB-3:0], 2'b00};
				if (!rtr[RTB+1]) begin
					rrem_q <= rtr; rres_q <= {rres_q[RTB-2:0], 1'b1};
				end else begin
					rrem_q <= rcur; rres_q <= {rres_q[RTB-2:0], 1'b0};
				end
			end
			if (cmd.emit) begin
				out_valid <= 1'b1;
				level <= lvn; block_index <= obi_q;
				min_peak <= omin_q; max_peak <= omax_q;
				rms_level <= SAMPLE_BITS'(rres_q);
				clipped <= final_q && clip_q;
				level_done <= final_q;
				last <= !more;
				lv_q <= lv_q + LVB'(1);
			end
		end
	end
endmodule
`default_nettype wire

[rtl/waveform_peak_rms_mipmap.sv]
// Waveform overview: per-frame mono mix, min/max/RMS over 11 block sizes.
// Each frame's mix is folded into every active level in turn: a level that emits runs the start,
// divide, root and emit steps (the emit waits while the output register is stalled); a skipped
// level only accumulates. in_stall is high outside the idle state, so the next sample is taken
// only after the previous one and all its level steps are finished.
// Reset: arst_n clears all clip state; channel_count resets to 1, total_frames to 0.
`default_nettype none
module waveform_peak_rms_mipmap #(
	parameter int NUM_LEVELS       = wprm_pkg::NUM_LEVELS,
	parameter int MAX_CHANNELS     = wprm_pkg::MAX_CHANNELS,
	parameter int SAMPLE_BITS      = wprm_pkg::SAMPLE_BITS,
	parameter int FRAME_COUNT_BITS = wprm_pkg::FRAME_COUNT_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [0:0]                          cfg_index,
	input  wire logic [FRAME_COUNT_BITS-1:0]         cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]       sample,
	input  wire logic                                first,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [wprm_pkg::LEVEL_BITS-1:0]          level,
	output logic [FRAME_COUNT_BITS-1:0]              block_index,
	output logic signed [SAMPLE_BITS-1:0]            min_peak,
	output logic signed [SAMPLE_BITS-1:0]            max_peak,
	output logic [SAMPLE_BITS-1:0]                   rms_level,
	output logic                                     clipped,
	output logic                                     level_done,
	output logic                                     last
);
	logic [wprm_pkg::CHAN_BITS-1:0] chcnt_q;
	logic [FRAME_COUNT_BITS-1:0] total_q;
	wprm_pkg::cmd_t cmd;
	wprm_pkg::sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chcnt_q <= wprm_pkg::CHAN_BITS'(1);
			total_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wprm_pkg::REG_CHANNEL_COUNT: chcnt_q <= cfg_data[wprm_pkg::CHAN_BITS-1:0];
				wprm_pkg::REG_TOTAL_FRAMES:  total_q <= cfg_data;
				default: ;
			endcase
		end
	end

	wprm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .cmd(cmd)
	);

	wprm_dp #(
		.NUM_LEVELS(NUM_LEVELS), .MAX_CHANNELS(MAX_CHANNELS),
		.SAMPLE_BITS(SAMPLE_BITS), .FRAME_COUNT_BITS(FRAME_COUNT_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.channel_count(chcnt_q), .total_frames(total_q),
		.sample(sample), .first(first),
		.out_valid(out_valid), .out_stall(out_stall),
		.level(level), .block_index(block_index), .min_peak(min_peak),
		.max_peak(max_peak), .rms_level(rms_level), .clipped(clipped),
		.level_done(level_done), .last(last)
	);
endmodule
`default_nettype wire
